[sv/integer_literal_scanner_top_assert.svh]
// Assertion macros for the integer literal scanner.
`ifndef INTEGER_LITERAL_SCANNER_TOP_ASSERT_SVH
`define INTEGER_LITERAL_SCANNER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Checked property, held off while reset is asserted
`define ILS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("integer_literal_scanner: assertion failed");
// Checked property, live through reset as well
`define ILS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("integer_literal_scanner: assertion failed");
`else
`define ILS_ASSERT(lbl, clk, rstn, prop)
`define ILS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[sv/ils_pkg.sv]
// Shared types and constants of the integer literal scanner.
package ils_pkg;

  localparam int unsigned VALUE_BITS_DEF = 64;

  // Characters of interest
  localparam logic [7:0] CH_ZERO       = 8'h30;
  localparam logic [7:0] CH_X          = 8'h78;
  localparam logic [7:0] CH_O          = 8'h6F;
  localparam logic [7:0] CH_B          = 8'h62;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_I          = 8'h69;
  localparam logic [7:0] CH_U          = 8'h75;
  localparam logic [7:0] CH_ONE        = 8'h31;
  localparam logic [7:0] CH_TWO        = 8'h32;
  localparam logic [7:0] CH_THREE      = 8'h33;
  localparam logic [7:0] CH_FOUR       = 8'h34;
  localparam logic [7:0] CH_SIX        = 8'h36;
  localparam logic [7:0] CH_EIGHT      = 8'h38;

  // Digit value meaning "not a digit"
  localparam logic [4:0] NO_DIGIT = 5'd16;

  // Suffix codes (signed variant; unsigned is one more)
  localparam logic [3:0] SFX_NONE = 4'd0;
  localparam logic [3:0] SFX_I8   = 4'd1;
  localparam logic [3:0] SFX_I16  = 4'd3;
  localparam logic [3:0] SFX_I32  = 4'd5;
  localparam logic [3:0] SFX_I64  = 4'd7;

  typedef enum logic [1:0] {
    PH_PREFIX = 2'd0,
    PH_DIGITS = 2'd1,
    PH_SUFFIX = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_HEX = 2'd1,
    RADIX_OCT = 2'd2,
    RADIX_BIN = 2'd3
  } radix_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_OVERFLOW   = 2'd1,
    ST_BAD_DIGIT  = 2'd2,
    ST_BAD_SUFFIX = 2'd3
  } status_e;

  // One input item
  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_item_t;

  // Result item fields other than the value
  typedef struct packed {
    logic [3:0] suffix_code;
    status_e    status;
  } res_tag_t;

endpackage

[sv/ils_in_if.sv]
// Input channel carrying one literal character per item.
interface ils_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

[sv/ils_out_if.sv]
// Output channel carrying one scan result per item.
interface ils_out_if import ils_pkg::*; #(
  parameter int unsigned ValueBits = VALUE_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [ValueBits-1:0] value;
  logic [3:0]           suffix_code;
  logic [1:0]           status;

  modport source (output valid, output value, output suffix_code, output status,
                  input ready);
  modport sink   (input valid, input value, input suffix_code, input status,
                  output ready);
endinterface

[sv/ils_in_stage.sv]
// Input register stage of the integer literal scanner.
module ils_in_stage import ils_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  in_item_t item_i,
  output logic     ready_o,
  input  logic     advance_i,
  output logic     valid_o,
  output in_item_t item_o
);

  logic     valid_q;
  in_item_t item_q;

  // Free slot, or the held item moves on this cycle
  assign ready_o = !valid_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[sv/ils_scan.sv]
// Scanner state and per-character update, result formed on the last character.
module ils_scan import ils_pkg::*; #(
  parameter int unsigned ValueBits = VALUE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  in_item_t             item_i,
  output logic                 res_valid_o,
  output logic [ValueBits-1:0] value_o,
  output res_tag_t             tag_o
);

  localparam int unsigned MacBits = ValueBits + 4;

  typedef struct packed {
    phase_e               phase;
    logic [ValueBits-1:0] acc;
    logic [23:0]          sfx;
    logic [2:0]           slen;
    status_e              err;
  } scan_t;

  // Digit value of a character, NO_DIGIT if none
  function automatic logic [4:0] digit_of(logic [7:0] c);
    logic [7:0] t;
    t = 8'h00;
    digit_of = NO_DIGIT;
    if (c >= 8'h30 && c <= 8'h39) begin
      t = c - 8'h30;
      digit_of = {1'b0, t[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      t = c - 8'h57;
      digit_of = {1'b0, t[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      t = c - 8'h37;
      digit_of = {1'b0, t[3:0]};
    end
  endfunction

  // State at the start of the digits, decimal
  function automatic scan_t fresh_st();
    scan_t s;
    s.phase = PH_DIGITS;
    s.acc   = '0;
    s.sfx   = '0;
    s.slen  = '0;
    s.err   = ST_OK;
    return s;
  endfunction

  // One character into digits or suffix
  function automatic scan_t feed(scan_t s, radix_e r, logic [7:0] c);
    scan_t              n;
    logic [4:0]         d;
    logic [4:0]         base;
    logic [MacBits-1:0] acc_x;
    logic [MacBits-1:0] d_x;
    logic [MacBits-1:0] mac;
    logic               skip;
    logic               is_dig;
    n      = s;
    d      = digit_of(c);
    acc_x  = {4'b0000, s.acc};
    d_x    = {{(MacBits-5){1'b0}}, d};
    case (r)
      RADIX_HEX: begin
        base = 5'd16;
        mac  = (acc_x << 4) + d_x;
      end
      RADIX_OCT: begin
        base = 5'd8;
        mac  = (acc_x << 3) + d_x;
      end
      RADIX_BIN: begin
        base = 5'd2;
        mac  = (acc_x << 1) + d_x;
      end
      default: begin
        base = 5'd10;
        mac  = (acc_x << 3) + (acc_x << 1) + d_x;
      end
    endcase
    skip   = (s.phase == PH_DIGITS) && (c == CH_UNDERSCORE);
    is_dig = (s.phase == PH_DIGITS) && (d != NO_DIGIT);
    if (s.err == ST_OK && !skip) begin
      if (is_dig) begin
        if (d >= base) begin
          n.err = ST_BAD_DIGIT;
        end else if (|mac[MacBits-1:ValueBits]) begin
          n.err = ST_OVERFLOW;
        end else begin
          n.acc = mac[ValueBits-1:0];
        end
      end else begin
        n.phase = PH_SUFFIX;
        case (s.slen)
          3'd0:    n.sfx[7:0]   = c;
          3'd1:    n.sfx[15:8]  = c;
          3'd2:    n.sfx[23:16] = c;
          default: n.sfx        = s.sfx;
        endcase
        if (s.slen < 3'd4) begin
          n.slen = s.slen + 3'd1;
        end
      end
    end
    return n;
  endfunction

  // Suffix decode: {bad, code}
  function automatic logic [4:0] lookup(logic [23:0] sfx, logic [2:0] slen);
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic [3:0] sgn;
    a   = sfx[7:0];
    b   = sfx[15:8];
    c   = sfx[23:16];
    sgn = {3'b000, (a == CH_U)};
    lookup = {1'b1, SFX_NONE};
    if (slen == 3'd0) begin
      lookup = {1'b0, SFX_NONE};
    end else if (a == CH_I || a == CH_U) begin
      if (slen == 3'd2 && b == CH_EIGHT) begin
        lookup = {1'b0, SFX_I8 + sgn};
      end else if (slen == 3'd3 && b == CH_ONE && c == CH_SIX) begin
        lookup = {1'b0, SFX_I16 + sgn};
      end else if (slen == 3'd3 && b == CH_THREE && c == CH_TWO) begin
        lookup = {1'b0, SFX_I32 + sgn};
      end else if (slen == 3'd3 && b == CH_SIX && c == CH_FOUR) begin
        lookup = {1'b0, SFX_I64 + sgn};
      end
    end
  endfunction

  phase_e               phase_q;
  radix_e               radix_q, radix_d;
  logic [ValueBits-1:0] acc_q;
  logic [15:0]          held_q, held_d;
  logic [1:0]           cnt_q, cnt_d;
  logic [23:0]          sfx_q;
  logic [2:0]           slen_q;
  status_e              err_q;

  scan_t      cur, pre_st, tail, fin;
  radix_e     pre_rad;
  logic [7:0] c, h0, h1;
  logic [4:0] sfx_res;
  logic       last;

  assign c    = item_i.char_code;
  assign last = item_i.last_char;
  assign h0   = held_q[7:0];
  assign h1   = held_q[15:8];

  // Prefix decode of the two held characters
  always_comb begin
    pre_rad = RADIX_DEC;
    if (h0 == CH_ZERO) begin
      case (h1)
        CH_X:    pre_rad = RADIX_HEX;
        CH_O:    pre_rad = RADIX_OCT;
        CH_B:    pre_rad = RADIX_BIN;
        default: pre_rad = RADIX_DEC;
      endcase
    end
  end

  // Next scan state; held characters start from zero
  always_comb begin
    cur.phase = phase_q;
    cur.acc   = acc_q;
    cur.sfx   = sfx_q;
    cur.slen  = slen_q;
    cur.err   = err_q;
    radix_d   = radix_q;
    held_d    = held_q;
    cnt_d     = cnt_q;
    pre_st    = fresh_st();
    tail      = fresh_st();
    fin       = cur;
    if (phase_q == PH_PREFIX) begin
      if (cnt_q[1]) begin
        held_d  = '0;
        cnt_d   = '0;
        radix_d = pre_rad;
        if (pre_rad == RADIX_DEC) begin
          pre_st = feed(feed(fresh_st(), RADIX_DEC, h0), RADIX_DEC, h1);
        end
        fin = feed(pre_st, pre_rad, c);
      end else begin
        held_d = cnt_q[0] ? {c, held_q[7:0]} : {8'h00, c};
        cnt_d  = cnt_q + 2'd1;
        if (cnt_q[0]) begin
          tail = feed(feed(fresh_st(), RADIX_DEC, h0), RADIX_DEC, c);
        end else begin
          tail = feed(fresh_st(), RADIX_DEC, c);
        end
        if (last) begin
          fin = tail;
        end
      end
    end else begin
      fin = feed(cur, radix_q, c);
    end
  end

  // Result of the literal
  always_comb begin
    sfx_res           = lookup(fin.sfx, fin.slen);
    res_valid_o       = fire_i && last;
    value_o           = '0;
    tag_o.suffix_code = SFX_NONE;
    tag_o.status      = fin.err;
    if (fin.err == ST_OK) begin
      if (sfx_res[4]) begin
        tag_o.status = ST_BAD_SUFFIX;
      end else begin
        tag_o.suffix_code = sfx_res[3:0];
        value_o           = fin.acc;
      end
    end
  end

  // State registers; a literal's end returns to the start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PREFIX;
      radix_q <= RADIX_DEC;
      acc_q   <= '0;
      held_q  <= '0;
      cnt_q   <= '0;
      sfx_q   <= '0;
      slen_q  <= '0;
      err_q   <= ST_OK;
    end else if (fire_i) begin
      if (last) begin
        phase_q <= PH_PREFIX;
        radix_q <= RADIX_DEC;
        acc_q   <= '0;
        held_q  <= '0;
        cnt_q   <= '0;
        sfx_q   <= '0;
        slen_q  <= '0;
        err_q   <= ST_OK;
      end else begin
        phase_q <= fin.phase;
        radix_q <= radix_d;
        acc_q   <= fin.acc;
        held_q  <= held_d;
        cnt_q   <= cnt_d;
        sfx_q   <= fin.sfx;
        slen_q  <= fin.slen;
        err_q   <= fin.err;
      end
    end
  end

endmodule

[sv/ils_out_stage.sv]
// Result register stage of the integer literal scanner.
module ils_out_stage import ils_pkg::*; #(
  parameter int unsigned ValueBits = VALUE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 res_valid_i,
  input  logic [ValueBits-1:0] value_i,
  input  res_tag_t             tag_i,
  output logic                 advance_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic [ValueBits-1:0] value_o,
  output res_tag_t             tag_o
);

  logic                 valid_q;
  logic [ValueBits-1:0] value_q;
  res_tag_t             tag_q;

  // Register free or being emptied this cycle
  assign advance_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && res_valid_i) begin
      value_q <= value_i;
      tag_q   <= tag_i;
    end
  end

  assign valid_o = valid_q;
  assign value_o = value_q;
  assign tag_o   = tag_q;

endmodule

[sv/integer_literal_scanner_top.sv]
// Integer literal scanner: one character per item in, one result per literal out.
// The last character is registered in the input register; the scanner forms its result
// combinationally from it, and that result is registered in the result register.
// Throughput: one character per cycle while a held result does not stall the input.
// Reset (asynchronous, active low) empties both stages and starts a new literal.
`include "integer_literal_scanner_top_assert.svh"
module integer_literal_scanner_top import ils_pkg::*; #(
  parameter int unsigned ValueBits = VALUE_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  ils_in_if.sink   in_i,
  ils_out_if.source out_o
);

  in_item_t             in_item;
  in_item_t             s1_item;
  logic                 s1_valid;
  logic                 s1_fire;
  logic                 advance;
  logic                 res_valid;
  logic [ValueBits-1:0] res_value;
  res_tag_t             res_tag;
  res_tag_t             out_tag;
  logic                 out_err;
  logic                 out_clear;
  logic                 out_held;
  logic                 last_fire;
  logic                 mid_fire;

  assign in_item.char_code = in_i.char_code;
  assign in_item.last_char = in_i.last_char;

  // Input register
  ils_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_i.valid),
    .item_i    (in_item),
    .ready_o   (in_i.ready),
    .advance_i (advance),
    .valid_o   (s1_valid),
    .item_o    (s1_item)
  );

  assign s1_fire = s1_valid && advance;

  // Scanner state and result logic
  ils_scan #(.ValueBits(ValueBits)) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (s1_fire),
    .item_i      (s1_item),
    .res_valid_o (res_valid),
    .value_o     (res_value),
    .tag_o       (res_tag)
  );

  // Result register
  ils_out_stage #(.ValueBits(ValueBits)) u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .value_i     (res_value),
    .tag_i       (res_tag),
    .advance_o   (advance),
    .valid_o     (out_o.valid),
    .ready_i     (out_o.ready),
    .value_o     (out_o.value),
    .tag_o       (out_tag)
  );

  assign out_o.suffix_code = out_tag.suffix_code;
  assign out_o.status      = out_tag.status;

  // Terms used by the checks
  assign out_err   = out_o.valid && (out_o.status != ST_OK);
  assign out_clear = (out_o.value == '0) && (out_o.suffix_code == SFX_NONE);
  assign out_held  = s1_valid && out_o.valid && !out_o.ready;
  assign last_fire = s1_fire && s1_item.last_char;
  assign mid_fire  = s1_fire && !s1_item.last_char;

  // Checks
  `ILS_ASSERT_ALWAYS(a_err_clears_fields, clk_i, out_err |-> out_clear)
  `ILS_ASSERT(a_stall_only_when_full, clk_i, rst_ni, !in_i.ready |-> out_held)
  `ILS_ASSERT(a_last_gives_result, clk_i, rst_ni, last_fire |=> out_o.valid)
  `ILS_ASSERT(a_inner_char_no_result, clk_i, rst_ni, mid_fire |=> !out_o.valid)

endmodule
